@@ hw/rtl/sppg_pkg.sv @@
// Package for the stepper position pulse generator.
// Holds field widths, register indexes, opcodes, reset values and the shared status type.
`timescale 1ns / 1ps

package sppg_pkg;

   // field widths
   localparam int unsigned POS_W   = 24;
   localparam int unsigned CNT_W   = 40;
   localparam int unsigned CFG_W   = 16;
   localparam int unsigned IDX_W   = 8;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_PULLEY_RADIUS = 8'd0;
   localparam logic [IDX_W-1:0] REG_STEPS_PER_REV = 8'd1;
   localparam logic [IDX_W-1:0] REG_HIGH_TICKS    = 8'd2;
   localparam logic [IDX_W-1:0] REG_LOW_TICKS     = 8'd3;

   // register reset values
   localparam logic [CFG_W-1:0] RST_PULLEY_RADIUS = 16'd16;
   localparam logic [CFG_W-1:0] RST_STEPS_PER_REV = 16'd3200;
   localparam logic [CFG_W-1:0] RST_HIGH_TICKS    = 16'd70;
   localparam logic [CFG_W-1:0] RST_LOW_TICKS     = 16'd1;

   // request opcodes
   localparam logic OP_SET_TARGET = 1'b0;
   localparam logic OP_TICK       = 1'b1;

   // status of the multiply/divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } muldiv_stat_type;

endpackage

@@ hw/rtl/sppg_muldiv.sv @@
// Shared multiply-then-divide unit: quotient = floor(mag * mult / divisor).
// A 24x16 multiply, then a restoring divide, one quotient bit per cycle. Uses sppg_pkg.
`timescale 1ns / 1ps

module sppg_muldiv
   import sppg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [POS_W-1:0]     mag,
   input  logic [CFG_W-1:0]     mult,
   input  logic [CFG_W-1:0]     divisor,
   output muldiv_stat_type      stat,
   output logic [CNT_W-1:0]     quotient
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam int unsigned BIT_W  = $clog2(CNT_W + 1);
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(CNT_W - 1);

   logic [1:0]        state_ff, state_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              done_ff, done_in;
   logic [POS_W-1:0]  mag_ff, mag_in;
   logic [CFG_W-1:0]  mult_ff, mult_in;
   logic [CFG_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]  quo_ff, quo_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [CFG_W:0]    rem_shift;
   logic [CFG_W:0]    rem_diff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, quo_ff[CNT_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      mag_in   = mag_ff;
      mult_in  = mult_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mag_in   = mag;
               mult_in  = mult;
               // a zero divisor counts as one
               div_in   = (divisor == '0) ? CFG_W'(1) : divisor;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            quo_in   = CNT_W'(mag_ff) * CNT_W'(mult_ff);
            rem_in   = '0;
            bit_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!rem_diff[CFG_W]) begin
               rem_in = rem_diff[CFG_W-1:0];
               quo_in = {quo_ff[CNT_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[CFG_W-1:0];
               quo_in = {quo_ff[CNT_W-2:0], 1'b0};
            end
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == LAST_BIT) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      bit_ff  <= bit_in;
      mag_ff  <= mag_in;
      mult_ff <= mult_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

@@ hw/rtl/stepper_position_pulse_generator.sv @@
// Top level of the step/direction pulse generator for one stepper axis.
// Uses sppg_pkg and the shared multiply/divide unit sppg_muldiv.
`timescale 1ns / 1ps

// A tick beat, or a set-target beat that arrives while pulses remain (and is
// rejected), is answered in the cycle after it is accepted. An accepted
// set-target beat passes through ST_START, which hands the magnitude to
// sppg_muldiv, then ST_CALC while the unit multiplies and runs its restoring
// divide until its done flag is seen, then ST_DONE, which updates the axis
// state and loads the response once the response register is free. req_stall
// stays high while a set-target beat is in the divider or while an unread response waits.
// Configuration is to be written through the csr_ port only while the block is idle; the block does not enforce this.

module stepper_position_pulse_generator
   import sppg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic signed [POS_W-1:0] req_target_position,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_step_level,
   output logic                    rsp_dir_level,
   output logic                    rsp_busy_res,
   output logic                    rsp_rejected,
   output logic [CNT_W-1:0]        rsp_pulses_left,
   // configuration channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_CALC  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // configuration registers
   logic [CFG_W-1:0] pulley_radius_ff, steps_per_rev_ff, high_ticks_ff, low_ticks_ff;

   // axis state
   logic [1:0]        state_ff, state_in;
   logic [POS_W-1:0]  prev_target_ff, prev_target_in;
   logic              forward_ff, forward_in;
   logic              dir_ff, dir_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic              step_ff, step_in;
   logic [CFG_W-1:0]  timer_ff, timer_in;

   // pending set-target work
   logic [POS_W-1:0]  new_target_ff, new_target_in;
   logic [POS_W-1:0]  mag_ff, mag_in;
   logic              flip_ff, flip_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_step_ff, rsp_step_in;
   logic              rsp_dir_ff, rsp_dir_in;
   logic              rsp_busy_ff, rsp_busy_in;
   logic              rsp_rej_ff, rsp_rej_in;
   logic [CNT_W-1:0]  rsp_left_ff, rsp_left_in;

   logic              out_free;
   logic              accept;
   logic              md_start;
   muldiv_stat_type   md_stat;
   logic [CNT_W-1:0]  md_quotient;

   logic [POS_W:0]    travel;
   logic [POS_W:0]    travel_neg;
   logic [CFG_W-1:0]  timer_inc;
   logic [CFG_W-1:0]  high_eff;
   logic [CFG_W-1:0]  low_eff;
   logic [CNT_W-1:0]  rem_dec;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // distance and its magnitude, 25 bits so the subtract cannot overflow
   assign travel     = {req_target_position[POS_W-1], req_target_position}
                       - {prev_target_ff[POS_W-1], prev_target_ff};
   assign travel_neg = -travel;

   // tick pacing helpers
   assign timer_inc = timer_ff + CFG_W'(1);
   assign high_eff  = (high_ticks_ff == '0) ? CFG_W'(1) : high_ticks_ff;
   assign low_eff   = (low_ticks_ff == '0) ? CFG_W'(1) : low_ticks_ff;
   assign rem_dec   = remaining_ff - CNT_W'(1);

   assign md_start = (state_ff == ST_START);

   sppg_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .mag      (mag_ff),
      .mult     (steps_per_rev_ff),
      .divisor  (pulley_radius_ff),
      .stat     (md_stat),
      .quotient (md_quotient)
   );

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      prev_target_in = prev_target_ff;
      forward_in     = forward_ff;
      dir_in         = dir_ff;
      remaining_in   = remaining_ff;
      step_in        = step_ff;
      timer_in       = timer_ff;
      new_target_in  = new_target_ff;
      mag_in         = mag_ff;
      flip_in        = flip_ff;
      rsp_rej_in     = rsp_rej_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_rej_in = 1'b0;
               if (req_op == OP_TICK) begin
                  rsp_valid_in = 1'b1;
                  if (remaining_ff != '0) begin
                     timer_in = timer_inc;
                     if (step_ff) begin
                        if (timer_inc >= high_eff) begin
                           step_in  = 1'b0;
                           timer_in = '0;
                        end
                     end else if (timer_inc >= low_eff) begin
                        remaining_in = rem_dec;
                        timer_in     = '0;
                        step_in      = (rem_dec != '0);
                     end
                  end
               end else if (remaining_ff != '0) begin
                  // busy: refuse the new target
                  rsp_valid_in = 1'b1;
                  rsp_rej_in   = 1'b1;
               end else begin
                  new_target_in = req_target_position;
                  mag_in        = travel[POS_W] ? travel_neg[POS_W-1:0]
                                                : travel[POS_W-1:0];
                  flip_in       = (travel[POS_W] && forward_ff)
                                  || (!travel[POS_W] && (travel != '0) && !forward_ff);
                  state_in      = ST_START;
               end
            end
         end
         ST_START: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (md_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               prev_target_in = new_target_ff;
               if (flip_ff) begin
                  forward_in = !forward_ff;
                  dir_in     = !dir_ff;
               end
               remaining_in = md_quotient;
               timer_in     = '0;
               step_in      = (md_quotient != '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response payload follows the updated state whenever a beat is loaded
   always_comb begin
      rsp_step_in = rsp_step_ff;
      rsp_dir_in  = rsp_dir_ff;
      rsp_busy_in = rsp_busy_ff;
      rsp_left_in = rsp_left_ff;
      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_step_in = step_in;
         rsp_dir_in  = dir_in;
         rsp_busy_in = (remaining_in != '0);
         rsp_left_in = remaining_in;
      end
   end

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pulley_radius_ff <= RST_PULLEY_RADIUS;
         steps_per_rev_ff <= RST_STEPS_PER_REV;
         high_ticks_ff    <= RST_HIGH_TICKS;
         low_ticks_ff     <= RST_LOW_TICKS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PULLEY_RADIUS: pulley_radius_ff <= csr_data;
            REG_STEPS_PER_REV: steps_per_rev_ff <= csr_data;
            REG_HIGH_TICKS:    high_ticks_ff    <= csr_data;
            REG_LOW_TICKS:     low_ticks_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_target_ff <= '0;
         forward_ff     <= 1'b1;
         dir_ff         <= 1'b0;
         remaining_ff   <= '0;
         step_ff        <= 1'b0;
         timer_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_rej_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_target_ff <= prev_target_in;
         forward_ff     <= forward_in;
         dir_ff         <= dir_in;
         remaining_ff   <= remaining_in;
         step_ff        <= step_in;
         timer_ff       <= timer_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_rej_ff     <= rsp_rej_in;
      end
      new_target_ff <= new_target_in;
      mag_ff        <= mag_in;
      flip_ff       <= flip_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_level  = rsp_step_ff;
   assign rsp_dir_level   = rsp_dir_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_pulses_left = rsp_left_ff;

endmodule

@@ hw/rtl/sppg_checker.sv @@
// Port-level checker for the stepper position pulse generator, bound to the top level.
// Uses sppg_pkg for field widths.
`timescale 1ns / 1ps

module sppg_checker
   import sppg_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_step_level,
   input logic             rsp_dir_level,
   input logic             rsp_busy_res,
   input logic             rsp_rejected,
   input logic [CNT_W-1:0] rsp_pulses_left
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pulses_left)
         && $stable(rsp_step_level) && $stable(rsp_dir_level) && $stable(rsp_rejected))
      else $error("response beat changed while stalled");

   // busy flag agrees with the pulse count
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_busy_res == (rsp_pulses_left != '0)))
      else $error("busy flag disagrees with pulses left");

   // a target is refused only while pulses remain
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("rejection reported while idle");

   // the step line rests low once the count is spent
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_step_level)
      else $error("step line high with no pulses left");

endmodule

bind stepper_position_pulse_generator sppg_checker u_sppg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_step_level  (rsp_step_level),
   .rsp_dir_level   (rsp_dir_level),
   .rsp_busy_res    (rsp_busy_res),
   .rsp_rejected    (rsp_rejected),
   .rsp_pulses_left (rsp_pulses_left)
);
